// ----- rtl/pfa_pkg.sv -----
`default_nettype none

package pfa_pkg;

    // frame geometry
    localparam int NUM_FRAMES  = 65536;
    localparam int FRAME_BYTES = 4096;
    localparam int PAGE_SHIFT  = $clog2(FRAME_BYTES);
    localparam int FRAME_W     = $clog2(NUM_FRAMES);

    // field widths
    localparam int ADDR_W  = 28;
    localparam int VIRT_W  = 48;
    localparam int VPAGE_W = VIRT_W - PAGE_SHIFT;
    localparam int TYPE_W  = 8;
    localparam int COUNT_W = 17;
    localparam int FNUM_W  = ADDR_W - PAGE_SHIFT;

    localparam logic [COUNT_W-1:0] FREE_LIMIT = COUNT_W'(NUM_FRAMES);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(NUM_FRAMES - 1);

    typedef enum logic [1:0] {
        FS_RESERVED = 2'd0,
        FS_FREE     = 2'd1,
        FS_INUSE    = 2'd2
    } t_frame_status;

    typedef enum logic [2:0] {
        ACT_SEED      = 3'd0,
        ACT_ALLOC     = 3'd1,
        ACT_FREE      = 3'd2,
        ACT_MAP       = 3'd3,
        ACT_UNMAP     = 3'd4,
        ACT_TRANSLATE = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        RC_OK          = 3'd0,
        RC_OUT_OF_MEM  = 3'd1,
        RC_NONE_IN_USE = 3'd2,
        RC_OVERFLOW    = 3'd3,
        RC_OUT_OF_RNG  = 3'd4,
        RC_PAGE_FREE   = 3'd5
    } t_result;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_RMW
    } t_state;

    // one row of the frame table
    typedef struct packed {
        logic [VPAGE_W-1:0] vpage;
        logic [TYPE_W-1:0]  ptype;
        t_frame_status      status;
    } t_frame_row;

    localparam int ROW_W = $bits(t_frame_row);

    typedef struct packed {
        logic               we;
        logic [FRAME_W-1:0] waddr;
        t_frame_row         wdata;
        logic [FRAME_W-1:0] raddr;
    } t_frame_req;

    typedef struct packed {
        logic               we;
        logic [FRAME_W-1:0] waddr;
        logic [FRAME_W-1:0] wdata;
        logic [FRAME_W-1:0] raddr;
    } t_stack_req;

endpackage

`default_nettype wire

// ----- rtl/pfa_ram.sv -----
`default_nettype none

module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/pfa_ctrl.sv -----
`default_nettype none

module pfa_ctrl
    import pfa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [2:0]         i_action,
    input  wire logic [ADDR_W-1:0]  i_page_addr,
    input  wire logic [VIRT_W-1:0]  i_virt_addr,
    input  wire logic [TYPE_W-1:0]  i_page_type,
    output logic                    o_done,
    output logic [2:0]              o_result_code,
    output logic [ADDR_W-1:0]       o_phys_addr,
    output logic [VIRT_W-1:0]       o_virt_out,
    output logic [COUNT_W-1:0]      o_free_count,
    output logic [COUNT_W-1:0]      o_used_count,
    output t_frame_req              o_frame_req,
    input  wire t_frame_row         i_frame_rdata,
    output t_stack_req              o_stack_req,
    input  wire logic [FRAME_W-1:0] i_stack_rdata
);

    t_state              r_state, n_state;
    logic [FRAME_W-1:0]  r_clr, n_clr;
    logic [COUNT_W-1:0]  r_free, n_free;
    logic [COUNT_W-1:0]  r_used, n_used;
    logic                r_done, n_done;
    t_result             r_code, n_code;
    logic [ADDR_W-1:0]   r_phys, n_phys;
    logic [VIRT_W-1:0]   r_virt, n_virt;
    t_action             r_action, n_action;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic [TYPE_W-1:0]   r_type, n_type;

    logic [FNUM_W-1:0]   frame_num;
    logic [FRAME_W-1:0]  frame_idx;
    logic                in_range;
    logic [COUNT_W-1:0]  top_idx;
    logic                stack_full;
    t_frame_row          row;

    // frame number of the incoming page address
    assign frame_num  = i_page_addr[ADDR_W-1:PAGE_SHIFT];
    assign frame_idx  = FRAME_W'(frame_num);
    assign in_range   = 32'(frame_num) < 32'(NUM_FRAMES);
    assign top_idx    = r_free - COUNT_W'(1);
    assign stack_full = r_free >= FREE_LIMIT;
    assign row        = i_frame_rdata;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_free  <= '0;
            r_used  <= '0;
            r_done  <= 1'b0;
            r_code  <= RC_OK;
            r_phys  <= '0;
            r_virt  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_free  <= n_free;
            r_used  <= n_used;
            r_done  <= n_done;
            r_code  <= n_code;
            r_phys  <= n_phys;
            r_virt  <= n_virt;
        end
    end

    // operation operands
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_frame  <= n_frame;
        r_type   <= n_type;
    end

    // next state, memory requests and results
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_free      = r_free;
        n_used      = r_used;
        n_done      = 1'b0;
        n_code      = r_code;
        n_phys      = r_phys;
        n_virt      = r_virt;
        n_action    = r_action;
        n_frame     = r_frame;
        n_type      = r_type;
        o_frame_req = '0;
        o_stack_req = '0;

        unique case (r_state)
            // sweep every frame to reserved after reset
            ST_CLEAR: begin
                o_frame_req.we    = 1'b1;
                o_frame_req.waddr = r_clr;
                o_frame_req.wdata = '0;
                n_clr             = r_clr + FRAME_W'(1);
                if (r_clr == LAST_FRAME) begin
                    n_state = ST_IDLE;
                end
            end

            // take a command, answer at once or start the memory read
            ST_IDLE: begin
                if (i_start) begin
                    n_action = t_action'(i_action);
                    n_frame  = frame_idx;
                    n_type   = i_page_type;
                    n_phys   = '0;
                    n_virt   = '0;
                    n_code   = RC_OK;
                    unique case (t_action'(i_action))
                        ACT_SEED, ACT_UNMAP, ACT_TRANSLATE: begin
                            if (!in_range) begin
                                n_done = 1'b1;
                                n_code = RC_OUT_OF_RNG;
                            end else begin
                                o_frame_req.raddr = frame_idx;
                                n_state           = ST_RMW;
                            end
                        end
                        ACT_ALLOC: begin
                            if (r_free == '0) begin
                                n_done = 1'b1;
                                n_code = RC_OUT_OF_MEM;
                            end else begin
                                o_stack_req.raddr = top_idx[FRAME_W-1:0];
                                n_state           = ST_POP;
                            end
                        end
                        ACT_FREE: begin
                            if (r_used == '0) begin
                                n_done = 1'b1;
                                n_code = RC_NONE_IN_USE;
                            end else if (!in_range) begin
                                n_done = 1'b1;
                                n_code = RC_OUT_OF_RNG;
                            end else begin
                                o_frame_req.raddr = frame_idx;
                                n_state           = ST_RMW;
                            end
                        end
                        ACT_MAP: begin
                            n_done = 1'b1;
                            if (!in_range) begin
                                n_code = RC_OUT_OF_RNG;
                            end else begin
                                o_frame_req.we           = 1'b1;
                                o_frame_req.waddr        = frame_idx;
                                o_frame_req.wdata.vpage  = i_virt_addr[VIRT_W-1:PAGE_SHIFT];
                                o_frame_req.wdata.ptype  = i_page_type;
                                o_frame_req.wdata.status = FS_INUSE;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            // top of stack is back: read that frame's row
            ST_POP: begin
                n_frame           = i_stack_rdata;
                o_frame_req.raddr = i_stack_rdata;
                n_state           = ST_RMW;
            end

            // row is back: modify, write and answer
            ST_RMW: begin
                n_state           = ST_IDLE;
                n_done            = 1'b1;
                n_code            = RC_OK;
                o_frame_req.waddr = r_frame;
                o_frame_req.wdata = row;
                o_stack_req.waddr = r_free[FRAME_W-1:0];
                o_stack_req.wdata = r_frame;
                unique case (r_action)
                    ACT_SEED, ACT_FREE: begin
                        if (row.status != FS_FREE) begin
                            if (stack_full) begin
                                n_code = RC_OVERFLOW;
                            end else begin
                                o_frame_req.we           = 1'b1;
                                o_frame_req.wdata.status = FS_FREE;
                                o_stack_req.we           = 1'b1;
                                n_free                   = r_free + COUNT_W'(1);
                                if (r_action == ACT_FREE) begin
                                    n_used = r_used - COUNT_W'(1);
                                end
                            end
                        end
                    end
                    ACT_ALLOC: begin
                        o_frame_req.we           = 1'b1;
                        o_frame_req.wdata.ptype  = r_type;
                        o_frame_req.wdata.status = FS_INUSE;
                        n_free                   = top_idx;
                        if (r_used != COUNT_MAX) begin
                            n_used = r_used + COUNT_W'(1);
                        end
                        n_phys = ADDR_W'({r_frame, {PAGE_SHIFT{1'b0}}});
                    end
                    ACT_UNMAP: begin
                        o_frame_req.we           = 1'b1;
                        o_frame_req.wdata.status = FS_FREE;
                    end
                    ACT_TRANSLATE: begin
                        if (row.status == FS_FREE) begin
                            n_code = RC_PAGE_FREE;
                        end else begin
                            n_virt = VIRT_W'({row.vpage, {PAGE_SHIFT{1'b0}}});
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_result_code = r_code;
    assign o_phys_addr   = r_phys;
    assign o_virt_out    = r_virt;
    assign o_free_count  = r_free;
    assign o_used_count  = r_used;

endmodule

`default_nettype wire

// ----- rtl/page_frame_allocator.sv -----
// Physical page frame allocator with a free-frame stack.
//
// Command channel: drive i_action, i_page_addr, i_virt_addr and i_page_type
// and raise start; the command transfers at the clock edge where start is
// high and busy is low. Every command gives one result, shown for exactly
// one cycle with o_done high; the receiver cannot hold it off.
//
// From the transfer to the cycle with o_done: map and any command refused
// up front need no table read; seed, free, unmap and translate do one
// read-modify-write of the frame table; allocate reads the stack, then does
// a frame table read-modify-write. busy covers those steps, so the next
// command can transfer while o_done is high. The single registered read
// port of the frame table sets these steps.
//
// After reset the frame table is swept to reserved, one frame a cycle, over
// all 65536 frames (NUM_FRAMES); busy stays high until the sweep is done. The
// counts read zero from reset and always show the state after the last
// result.
`default_nettype none

module page_frame_allocator
    import pfa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        i_action,
    input  wire logic [ADDR_W-1:0] i_page_addr,
    input  wire logic [VIRT_W-1:0] i_virt_addr,
    input  wire logic [TYPE_W-1:0] i_page_type,
    output logic                   o_done,
    output logic [2:0]             o_result_code,
    output logic [ADDR_W-1:0]      o_phys_addr,
    output logic [VIRT_W-1:0]      o_virt_out,
    output logic [COUNT_W-1:0]     o_free_count,
    output logic [COUNT_W-1:0]     o_used_count
);

    t_frame_req         frame_req;
    t_stack_req         stack_req;
    logic [ROW_W-1:0]   frame_rdata;
    logic [FRAME_W-1:0] stack_rdata;

    // command sequencer and counts
    pfa_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_action      (i_action),
        .i_page_addr   (i_page_addr),
        .i_virt_addr   (i_virt_addr),
        .i_page_type   (i_page_type),
        .o_done        (o_done),
        .o_result_code (o_result_code),
        .o_phys_addr   (o_phys_addr),
        .o_virt_out    (o_virt_out),
        .o_free_count  (o_free_count),
        .o_used_count  (o_used_count),
        .o_frame_req   (frame_req),
        .i_frame_rdata (frame_rdata),
        .o_stack_req   (stack_req),
        .i_stack_rdata (stack_rdata)
    );

    // status, type and virtual page per frame
    pfa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_FRAMES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (frame_req.we),
        .i_waddr (frame_req.waddr),
        .i_wdata (frame_req.wdata),
        .i_raddr (frame_req.raddr),
        .o_rdata (frame_rdata)
    );

    // stack of free frame numbers
    pfa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (NUM_FRAMES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_req.we),
        .i_waddr (stack_req.waddr),
        .i_wdata (stack_req.wdata),
        .i_raddr (stack_req.raddr),
        .o_rdata (stack_rdata)
    );

endmodule

`default_nettype wire

// ----- rtl/pfa_checker.sv -----
`default_nettype none

module pfa_checker
    import pfa_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_done,
    input wire logic [2:0]         o_result_code,
    input wire logic [ADDR_W-1:0]  o_phys_addr,
    input wire logic [VIRT_W-1:0]  o_virt_out,
    input wire logic [COUNT_W-1:0] o_free_count,
    input wire logic [COUNT_W-1:0] o_used_count
);

    // a transfer is either answered at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("transfer neither answered nor busy");

    // refused commands return no addresses
    a_error_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result_code != RC_OK) |-> (o_phys_addr == '0 && o_virt_out == '0))
        else $error("address returned with an error code");

    // out of memory only with an empty stack
    a_oom_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result_code == RC_OUT_OF_MEM) |-> (o_free_count == '0))
        else $error("out of memory with free frames left");

    // counts move only with a result
    a_counts_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !o_done) |-> ($stable(o_free_count) && $stable(o_used_count)))
        else $error("counts changed without a result");

    // free count never exceeds the number of frames
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_free_count <= FREE_LIMIT))
        else $error("free count above frame total");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (.*);

`default_nettype wire

// ----- bench/page_frame_allocator_test.sv -----
`timescale 1ns / 1ps

module page_frame_allocator_test;
    import pfa_pkg::*;

    localparam int QUIET_LIMIT = 4 * NUM_FRAMES;
    localparam int RAND_ITEMS  = 1600;
    localparam int POOL_SIZE   = 24;
    localparam int MAX_AHEAD   = 64;

    // actions the block does not know, answered ok with no change
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] paddr;
        logic [VIRT_W-1:0] vaddr;
        logic [TYPE_W-1:0] ptype;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         code;
        logic [ADDR_W-1:0]  paddr;
        logic [VIRT_W-1:0]  vaddr;
        logic [COUNT_W-1:0] nfree;
        logic [COUNT_W-1:0] nused;
    } t_reply;

    typedef struct packed {
        t_cmd   cmd;
        t_reply reply;
    } t_job;

    typedef struct packed {
        t_reply      reply;
        logic [31:0] stamp;
    } t_awaited;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic [2:0]         i_action    = '0;
    logic [ADDR_W-1:0]  i_page_addr = '0;
    logic [VIRT_W-1:0]  i_virt_addr = '0;
    logic [TYPE_W-1:0]  i_page_type = '0;
    logic               busy;
    logic               o_done;
    logic [2:0]         o_result_code;
    logic [ADDR_W-1:0]  o_phys_addr;
    logic [VIRT_W-1:0]  o_virt_out;
    logic [COUNT_W-1:0] o_free_count;
    logic [COUNT_W-1:0] o_used_count;

    page_frame_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_page_addr   (i_page_addr),
        .i_virt_addr   (i_virt_addr),
        .i_page_type   (i_page_type),
        .o_done        (o_done),
        .o_result_code (o_result_code),
        .o_phys_addr   (o_phys_addr),
        .o_virt_out    (o_virt_out),
        .o_free_count  (o_free_count),
        .o_used_count  (o_used_count)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the frame table, the free stack and the counts
    t_frame_status      frame_state  [NUM_FRAMES];
    logic [VPAGE_W-1:0] frame_vpage  [NUM_FRAMES];
    bit                 frame_mapped [NUM_FRAMES];
    logic [FRAME_W-1:0] free_frames  [NUM_FRAMES];
    logic [COUNT_W-1:0] free_depth;
    logic [COUNT_W-1:0] used_depth;

    t_job               pending [$];
    t_awaited           awaited [$];
    t_job               cur;
    t_awaited           arrival;
    t_awaited           front;
    t_reply             last_reply;
    logic               took;
    int unsigned        idle_pct = 8;
    int unsigned        issued   = 0;
    int unsigned        n_bad    = 0;
    int unsigned        quiet    = 0;
    logic [31:0]        cycle_no = '0;
    logic [FRAME_W-1:0] frame_pool [POOL_SIZE];

    // push a frame onto the free stack unless it is full
    function automatic logic [2:0] push_free(logic [FRAME_W-1:0] fn);
        if (free_depth >= FREE_LIMIT)
            return RC_OVERFLOW;
        frame_state[fn] = FS_FREE;
        free_frames[FRAME_W'(free_depth)] = fn;
        free_depth = free_depth + 1'b1;
        return RC_OK;
    endfunction

    // one command against the shadow state, giving the reply it must produce
    function automatic t_reply apply_cmd(t_cmd c);
        t_reply             r;
        logic [FNUM_W-1:0]  fnum;
        logic [FRAME_W-1:0] fn;
        logic [FRAME_W-1:0] top;
        logic               in_range;
        r        = '0;
        fnum     = c.paddr[ADDR_W-1:PAGE_SHIFT];
        in_range = fnum < NUM_FRAMES;
        fn       = FRAME_W'(fnum);
        case (c.action)
            ACT_SEED: begin
                if (!in_range)
                    r.code = RC_OUT_OF_RNG;
                else if (frame_state[fn] != FS_FREE)
                    r.code = push_free(fn);
            end
            ACT_ALLOC: begin
                if (free_depth == '0) begin
                    r.code = RC_OUT_OF_MEM;
                end else begin
                    top = free_frames[FRAME_W'(free_depth - 1'b1)];
                    free_depth = free_depth - 1'b1;
                    frame_state[top] = FS_INUSE;
                    if (used_depth != COUNT_MAX)
                        used_depth = used_depth + 1'b1;
                    r.paddr = ADDR_W'({top, {PAGE_SHIFT{1'b0}}});
                end
            end
            ACT_FREE: begin
                if (used_depth == '0) begin
                    r.code = RC_NONE_IN_USE;
                end else if (!in_range) begin
                    r.code = RC_OUT_OF_RNG;
                end else if (frame_state[fn] != FS_FREE) begin
                    r.code = push_free(fn);
                    if (r.code == RC_OK)
                        used_depth = used_depth - 1'b1;
                end
            end
            ACT_MAP: begin
                if (!in_range) begin
                    r.code = RC_OUT_OF_RNG;
                end else begin
                    frame_state[fn]  = FS_INUSE;
                    frame_vpage[fn]  = c.vaddr[VIRT_W-1:PAGE_SHIFT];
                    frame_mapped[fn] = 1'b1;
                end
            end
            ACT_UNMAP: begin
                if (!in_range)
                    r.code = RC_OUT_OF_RNG;
                else
                    frame_state[fn] = FS_FREE;
            end
            ACT_TRANSLATE: begin
                if (!in_range)
                    r.code = RC_OUT_OF_RNG;
                else if (frame_state[fn] == FS_FREE)
                    r.code = RC_PAGE_FREE;
                else
                    r.vaddr = {frame_vpage[fn], {PAGE_SHIFT{1'b0}}};
            end
            default: ;
        endcase
        r.nfree = free_depth;
        r.nused = used_depth;
        return r;
    endfunction

    // a translate must never read a virtual page that was never written
    function automatic bit safe_to_read(logic [ADDR_W-1:0] pa);
        logic [FRAME_W-1:0] fn;
        fn = FRAME_W'(pa >> PAGE_SHIFT);
        return frame_state[fn] == FS_FREE || frame_mapped[fn];
    endfunction

    // mostly frames from a small pool so that commands meet each other
    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [FRAME_W-1:0] fn;
        if ($urandom_range(0, 99) < 15)
            return ADDR_W'($urandom);
        fn = frame_pool[$urandom_range(0, POOL_SIZE - 1)];
        return ADDR_W'({fn, PAGE_SHIFT'($urandom)});
    endfunction

    function automatic logic [VIRT_W-1:0] rand_virt();
        return VIRT_W'({$urandom, $urandom});
    endfunction

    // predict a command and queue it for the driver
    task automatic issue(input logic [2:0] act, input logic [ADDR_W-1:0] pa,
                         input logic [VIRT_W-1:0] va, input logic [TYPE_W-1:0] pt);
        t_job j;
        j.cmd.action = act;
        j.cmd.paddr  = pa;
        j.cmd.vaddr  = va;
        j.cmd.ptype  = pt;
        j.reply      = apply_cmd(j.cmd);
        last_reply   = j.reply;
        while (pending.size() >= MAX_AHEAD)
            @(negedge i_clk);
        pending.push_back(j);
        issued++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            n_bad++;
            $display("%0t: %s expected 'h%0h, actual 'h%0h", $time, name, want, got);
        end
    endtask

    // command driver: hold a command until it transfers, then take the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            took = start && !busy;
            if (took) begin
                arrival.reply = cur.reply;
                arrival.stamp = cycle_no;
                awaited.push_back(arrival);
            end
            if (!start || took) begin
                if (pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    cur = pending.pop_front();
                    start       <= 1'b1;
                    i_action    <= cur.cmd.action;
                    i_page_addr <= cur.cmd.paddr;
                    i_virt_addr <= cur.cmd.vaddr;
                    i_page_type <= cur.cmd.ptype;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor: every strobe is checked against the oldest transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (awaited.size() == 0 || awaited[0].stamp == cycle_no) begin
                n_bad++;
                $display("%0t: result with no command waiting, code %0d",
                         $time, o_result_code);
            end else begin
                front = awaited.pop_front();
                check_field("result_code", front.reply.code,  o_result_code);
                check_field("phys_addr",   front.reply.paddr, o_phys_addr);
                check_field("virt_out",    front.reply.vaddr, o_virt_out);
                check_field("free_count",  front.reply.nfree, o_free_count);
                check_field("used_count",  front.reply.nused, o_used_count);
            end
        end
    end

    // watchdog on cycles with neither a transfer nor a result
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1'b1;
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // reset, stimulus and end of run
    initial begin
        logic [ADDR_W-1:0] pa;
        logic [2:0]        act;
        int unsigned       roll;
        int unsigned       tries;
        int unsigned       base;

        for (int f = 0; f < NUM_FRAMES; f++) begin
            frame_state[f]  = FS_RESERVED;
            frame_mapped[f] = 1'b0;
        end
        free_depth = '0;
        used_depth = '0;
        frame_pool[0] = '0;
        frame_pool[1] = '1;
        frame_pool[2] = FRAME_W'(1);
        for (int k = 3; k < POOL_SIZE; k++)
            frame_pool[k] = FRAME_W'($urandom);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty stack, nothing in use, free pages, duplicates on the stack
        issue(ACT_ALLOC, '0, '0, '0);
        issue(ACT_FREE, '0, '0, '0);
        issue(ACT_SEED, ADDR_W'(12'hABC), '0, '0);
        issue(ACT_TRANSLATE, '0, '0, '0);
        issue(ACT_SEED, '0, '1, '1);
        issue(ACT_SEED, '1, '0, '0);
        issue(ACT_ALLOC, '1, '1, '1);
        issue(ACT_MAP, '1, '1, '0);
        issue(ACT_TRANSLATE, '1, '0, '1);
        issue(ACT_MAP, '0, '0, '1);
        issue(ACT_TRANSLATE, ADDR_W'(12'hFFF), '1, '0);
        issue(ACT_SEED, '0, '0, '0);
        issue(ACT_ALLOC, '0, '0, 8'h5A);
        issue(ACT_ALLOC, '0, '0, 8'hA5);
        issue(ACT_ALLOC, '0, '0, '0);
        issue(ACT_FREE, '1, '0, '0);
        issue(ACT_FREE, '1, '0, '0);
        issue(ACT_UNMAP, '0, '0, '0);
        issue(ACT_TRANSLATE, '0, '0, '0);
        issue(ACT_FREE, '0, '0, '0);
        issue(ACT_MAP, 28'h5555555, 48'hAAAA_AAAA_AAAA, 8'h55);
        issue(ACT_TRANSLATE, 28'h5555555, 48'h5555_5555_5555, 8'hAA);
        issue(ACT_MAP, 28'hAAAAAAA, 48'h5555_5555_5555, 8'hAA);
        issue(ACT_TRANSLATE, 28'hAAAAAAA, 48'hAAAA_AAAA_AAAA, 8'h55);
        issue(ACT_SPARE6, '1, '1, '1);
        issue(ACT_SPARE7, '0, '0, '0);

        // random: page life cycles mixed with single commands
        base = issued;
        while (issued < base + RAND_ITEMS) begin
            idle_pct = (issued >= base + 700 && issued < base + 1000) ? 0 : 8;
            if ($urandom_range(0, 3) == 0) begin
                issue(ACT_SEED, pick_addr(), rand_virt(), TYPE_W'($urandom));
                issue(ACT_ALLOC, pick_addr(), rand_virt(), TYPE_W'($urandom));
                if (last_reply.code == RC_OK) begin
                    pa = last_reply.paddr | ADDR_W'($urandom_range(0, FRAME_BYTES - 1));
                    issue(ACT_MAP, pa, rand_virt(), TYPE_W'($urandom));
                    issue(ACT_TRANSLATE, pa, rand_virt(), TYPE_W'($urandom));
                    if ($urandom_range(0, 1) == 0)
                        issue(ACT_FREE, pa, rand_virt(), TYPE_W'($urandom));
                    else
                        issue(ACT_UNMAP, pa, rand_virt(), TYPE_W'($urandom));
                end
            end else begin
                roll = $urandom_range(0, 99);
                pa   = pick_addr();
                act  = roll < 18 ? ACT_SEED :
                       roll < 38 ? ACT_ALLOC :
                       roll < 58 ? ACT_FREE :
                       roll < 72 ? ACT_MAP :
                       roll < 80 ? ACT_UNMAP :
                       roll < 95 ? ACT_TRANSLATE : 3'($urandom_range(6, 7));
                if (act == ACT_TRANSLATE) begin
                    tries = 0;
                    while (!safe_to_read(pa) && tries < 8) begin
                        pa = pick_addr();
                        tries++;
                    end
                    if (!safe_to_read(pa))
                        act = ACT_MAP;
                end
                issue(act, pa, rand_virt(), TYPE_W'($urandom));
            end
        end

        // drain: last transfer, last result, then spare cycles before the verdict
        while (pending.size() != 0 || start)
            @(negedge i_clk);
        while (awaited.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (n_bad == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
